>>> rtl/jsu_pkg.sv
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 4;
  localparam int unsigned MaxRes  = 4;
  localparam int unsigned CntW    = $clog2(MaxRes + 1);
  localparam int unsigned IdxW    = $clog2(MaxRes);
  localparam int unsigned CpW     = 21;

  typedef enum logic [StatusW-1:0] {
    ST_BYTE         = 4'd0,
    ST_DONE         = 4'd1,
    ST_NO_OPEN      = 4'd2,
    ST_ESC_AT_END   = 4'd3,
    ST_BAD_ESC      = 4'd4,
    ST_SHORT_HEX    = 4'd5,
    ST_BAD_HEX      = 4'd6,
    ST_LONE_HIGH    = 4'd7,
    ST_BAD_LOW      = 4'd8,
    ST_LONE_LOW     = 4'd9,
    ST_UNTERMINATED = 4'd10
  } status_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_STR,
    MODE_ESC,
    MODE_HEX1,
    MODE_SBS,
    MODE_SU,
    MODE_HEX2
  } mode_e;

  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              cnt;
  } utf8_t;

endpackage

>>> rtl/jsu_if.sv
interface jsu_in_if;
  logic                       valid;
  logic                       ready;
  logic [jsu_pkg::ByteW-1:0]  in_byte;
  logic                       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic                         valid;
  logic                         ready;
  logic [jsu_pkg::ByteW-1:0]    data_byte;
  logic [jsu_pkg::StatusW-1:0]  status;
  logic                         last;

  modport source (output valid, data_byte, status, last, input ready);
  modport sink   (input valid, data_byte, status, last, output ready);
endinterface

>>> rtl/json_string_unescape.sv
// Streaming JSON string unescaper. Feed the literal one byte per request,
// starting at the opening quote; an end_of_text request closes the text. Each
// accepted request yields 0 to 4 result requests (UTF-8 bytes, or one status
// with last set), which appear in the cycle after acceptance and leave one per
// cycle while the output is ready, from a four-entry result buffer. The input
// takes a request every cycle while the previous request's results are gone or
// the last of them leaves in that cycle, so a code point of more than one byte
// holds the input while its bytes drain. An error or the closing quote returns
// the block to idle, awaiting the next opening quote.
module json_string_unescape (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  localparam logic [ByteW-1:0] ChQuote  = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChSlash  = 8'h2F;
  localparam logic [ByteW-1:0] ChB      = 8'h62;
  localparam logic [ByteW-1:0] ChF      = 8'h66;
  localparam logic [ByteW-1:0] ChN      = 8'h6E;
  localparam logic [ByteW-1:0] ChR      = 8'h72;
  localparam logic [ByteW-1:0] ChT      = 8'h74;
  localparam logic [ByteW-1:0] ChU      = 8'h75;

  mode_e                     mode_q, mode_d;
  logic [15:0]               hex_q, hex_d;
  logic [1:0]                dc_q, dc_d;
  logic [9:0]                hh_q, hh_d;

  logic [MaxRes-1:0][ByteW-1:0] buf_q;
  logic [CntW-1:0]              cnt_q;
  logic [IdxW-1:0]              idx_q;
  status_e                      st_q;

  logic [MaxRes-1:0][ByteW-1:0] res_bytes;
  logic [CntW-1:0]              res_cnt;
  status_e                      res_st;

  logic        in_acc, out_acc, out_last;
  logic [4:0]  hexv;
  logic [15:0] acc_new;
  logic [CpW-1:0] cp;
  utf8_t       enc;
  logic [ByteW-1:0] c;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [CpW-1:0] p);
    utf8_t r;
    r.bytes = '0;
    if (p <= 21'h7F) begin
      r.bytes[0] = p[7:0];
      r.cnt      = CntW'(1);
    end else if (p <= 21'h7FF) begin
      r.bytes[0] = 8'hC0 | {3'b000, p[10:6]};
      r.bytes[1] = 8'h80 | {2'b00, p[5:0]};
      r.cnt      = CntW'(2);
    end else if (p <= 21'hFFFF) begin
      r.bytes[0] = 8'hE0 | {4'h0, p[15:12]};
      r.bytes[1] = 8'h80 | {2'b00, p[11:6]};
      r.bytes[2] = 8'h80 | {2'b00, p[5:0]};
      r.cnt      = CntW'(3);
    end else begin
      r.bytes[0] = 8'hF0 | {5'b00000, p[20:18]};
      r.bytes[1] = 8'h80 | {2'b00, p[17:12]};
      r.bytes[2] = 8'h80 | {2'b00, p[11:6]};
      r.bytes[3] = 8'h80 | {2'b00, p[5:0]};
      r.cnt      = CntW'(4);
    end
    return r;
  endfunction

  assign out_last = ({1'b0, idx_q} == (cnt_q - CntW'(1)));
  assign out_acc  = out_o.valid && out_o.ready;
  assign in_i.ready = (cnt_q == '0) || (out_o.ready && out_last);
  assign in_acc   = in_i.valid && in_i.ready;

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.data_byte = buf_q[idx_q];
  assign out_o.status    = st_q;
  assign out_o.last      = out_last;

  assign c       = in_i.in_byte;
  assign hexv    = hex_value(c);
  assign acc_new = {hex_q[11:0], hexv[3:0]};

  always_comb begin
    mode_d    = mode_q;
    hex_d     = hex_q;
    dc_d      = dc_q;
    hh_d      = hh_q;
    res_bytes = '0;
    res_cnt   = '0;
    res_st    = ST_BYTE;
    cp        = {5'd0, acc_new};
    enc       = '0;
    unique case (mode_q) inside
      MODE_IDLE: begin
        if (!in_i.end_of_text && c == ChQuote) begin
          mode_d = MODE_STR;
        end else begin
          res_cnt = CntW'(1);
          res_st  = ST_NO_OPEN;
        end
      end
      MODE_STR: begin
        if (in_i.end_of_text) begin
          res_cnt = CntW'(1);
          res_st  = ST_UNTERMINATED;
        end else if (c == ChQuote) begin
          res_cnt = CntW'(1);
          res_st  = ST_DONE;
        end else if (c == ChBslash) begin
          mode_d = MODE_ESC;
        end else begin
          res_bytes[0] = c;
          res_cnt      = CntW'(1);
        end
      end
      MODE_ESC: begin
        mode_d = MODE_STR;
        res_cnt = CntW'(1);
        if (in_i.end_of_text) begin
          res_st = ST_ESC_AT_END;
        end else begin
          case (c) inside
            ChQuote, ChBslash, ChSlash: res_bytes[0] = c;
            ChB: res_bytes[0] = 8'h08;
            ChF: res_bytes[0] = 8'h0C;
            ChN: res_bytes[0] = 8'h0A;
            ChR: res_bytes[0] = 8'h0D;
            ChT: res_bytes[0] = 8'h09;
            ChU: begin
              mode_d  = MODE_HEX1;
              hex_d   = '0;
              dc_d    = '0;
              res_cnt = '0;
            end
            default: res_st = ST_BAD_ESC;
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2: begin
        if (in_i.end_of_text) begin
          res_cnt = CntW'(1);
          res_st  = ST_SHORT_HEX;
        end else if (!hexv[4]) begin
          res_cnt = CntW'(1);
          res_st  = ST_BAD_HEX;
        end else if (dc_q != 2'd3) begin
          hex_d = acc_new;
          dc_d  = dc_q + 2'd1;
        end else begin
          hex_d = '0;
          dc_d  = '0;
          if (mode_q == MODE_HEX1) begin
            if (acc_new[15:10] == 6'b110110) begin
              hh_d   = acc_new[9:0];
              mode_d = MODE_SBS;
            end else if (acc_new[15:10] == 6'b110111) begin
              res_cnt = CntW'(1);
              res_st  = ST_LONE_LOW;
            end else begin
              mode_d    = MODE_STR;
              enc       = utf8_enc(cp);
              res_bytes = enc.bytes;
              res_cnt   = enc.cnt;
            end
          end else begin
            if (acc_new[15:10] != 6'b110111) begin
              res_cnt = CntW'(1);
              res_st  = ST_BAD_LOW;
            end else begin
              // join the two halves into one supplementary code point
              cp        = 21'h10000 + {1'b0, hh_q, acc_new[9:0]};
              hh_d      = '0;
              mode_d    = MODE_STR;
              enc       = utf8_enc(cp);
              res_bytes = enc.bytes;
              res_cnt   = enc.cnt;
            end
          end
        end
      end
      MODE_SBS: begin
        if (in_i.end_of_text || c != ChBslash) begin
          res_cnt = CntW'(1);
          res_st  = ST_LONE_HIGH;
        end else begin
          mode_d = MODE_SU;
        end
      end
      MODE_SU: begin
        if (in_i.end_of_text || c != ChU) begin
          res_cnt = CntW'(1);
          res_st  = ST_LONE_HIGH;
        end else begin
          mode_d = MODE_HEX2;
          hex_d  = '0;
          dc_d   = '0;
        end
      end
      default: begin
        mode_d = MODE_IDLE;
        hex_d  = '0;
        dc_d   = '0;
        hh_d   = '0;
      end
    endcase
    // any status other than a data byte ends the string
    if (res_st != ST_BYTE) begin
      mode_d = MODE_IDLE;
      hex_d  = '0;
      dc_d   = '0;
      hh_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hex_q  <= '0;
      dc_q   <= '0;
      hh_q   <= '0;
    end else if (in_acc) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      dc_q   <= dc_d;
      hh_q   <= hh_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (in_acc) begin
      cnt_q <= res_cnt;
      idx_q <= '0;
    end else if (out_acc) begin
      if (out_last) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      buf_q <= res_bytes;
      st_q  <= res_st;
    end
  end

  a_stall_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_last) |-> !in_i.ready)
    else $error("input taken while earlier results still pending");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_BYTE) |-> (out_o.last && out_o.data_byte == 8'h00))
    else $error("status result not single and zero");

  a_status_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_st != ST_BYTE) |=> (mode_q == MODE_IDLE && hh_q == '0 && dc_q == '0))
    else $error("block not idle after status result");

endmodule
